// ===== rtl/prewitt_gradient_and_frame_difference_top_assert.svh =====
// Assertion macros for the Prewitt gradient / frame difference block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef PREWITT_GRADIENT_AND_FRAME_DIFFERENCE_TOP_ASSERT_SVH
`define PREWITT_GRADIENT_AND_FRAME_DIFFERENCE_TOP_ASSERT_SVH
`ifndef SYNTH
// check that an expression holds at every edge out of reset
`define PGFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// check that the consequent holds in the cycle of the antecedent
`define PGFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`else
`define PGFD_ASSERT(lbl, prop, msg)
`define PGFD_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pgfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the Prewitt gradient / frame difference block.
// No dependencies.
package pgfd_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int GRAD_W     = 11;
	localparam int TD_W       = 9;
	localparam int COLSUM_W   = 10;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 32;

	// gray = (1868*B + 9617*G + 4899*R + 8192) >> 14, all sums fit 22 bits
	localparam int GRAY_SUM_W = 22;
	localparam logic [GRAY_SUM_W-1:0] COEF_B     = 22'd1868;
	localparam logic [GRAY_SUM_W-1:0] COEF_G     = 22'd9617;
	localparam logic [GRAY_SUM_W-1:0] COEF_R     = 22'd4899;
	localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND = 22'd8192;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	// line memory entry at one column: two rows of gray and the newer row's difference
	typedef struct packed {
		logic [PIX_W-1:0]       older;
		logic [PIX_W-1:0]       newer;
		logic signed [TD_W-1:0] diff;
	} line_entry_t;

	// one 3-high column of the window, border mirroring already applied
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_vec_t;

	// per-column partial results: sum of the column, bottom minus top
	typedef struct packed {
		logic [COLSUM_W-1:0]    sum;
		logic signed [TD_W-1:0] dif;
	} col_stat_t;

	// window control from the pipeline
	typedef struct packed {
		logic shift;   // item leaves the window stage
		logic wrap;    // centre is the last column of a row
		logic lmir;    // centre is column zero
	} win_ctl_t;

endpackage

// ===== rtl/pgfd_frame_store.sv =====
`timescale 1ns / 1ps
// Previous-frame gray memory with a zeroing sweep after reset.
// Depends on nothing but its address width parameter.
module pgfd_frame_store #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	output logic          busy
);

	localparam int DEPTH = 1 << AW;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == {AW{1'b1}}) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_q;

endmodule

// ===== rtl/pgfd_window.sv =====
`timescale 1ns / 1ps
// 3x3 window over column vectors and Prewitt gradient sums.
// Depends on pgfd_pkg.
module pgfd_window (
	input  logic                                 clk,
	input  pgfd_pkg::win_ctl_t                   ctl,
	input  pgfd_pkg::col_vec_t                   vec,
	output logic signed [pgfd_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [pgfd_pkg::GRAD_W-1:0]   grad_y
);

	pgfd_pkg::col_stat_t a_q, b_q;     // columns centre-1 and centre
	pgfd_pkg::col_stat_t n_st, l_st, r_st;

	always_comb begin
		n_st.sum = pgfd_pkg::COLSUM_W'(vec.top) + pgfd_pkg::COLSUM_W'(vec.mid)
			+ pgfd_pkg::COLSUM_W'(vec.bot);
		n_st.dif = $signed({1'b0, vec.bot}) - $signed({1'b0, vec.top});
		// last column: right neighbor mirrors to the left one
		if (ctl.wrap) begin
			l_st = a_q;
			r_st = a_q;
		end else begin
			l_st = ctl.lmir ? n_st : a_q;
			r_st = n_st;
		end
		grad_x = $signed({1'b0, r_st.sum}) - $signed({1'b0, l_st.sum});
		grad_y = pgfd_pkg::GRAD_W'(l_st.dif) + pgfd_pkg::GRAD_W'(b_q.dif)
			+ pgfd_pkg::GRAD_W'(r_st.dif);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			a_q <= b_q;
			b_q <= n_st;
		end
	end

endmodule

// ===== rtl/prewitt_gradient_and_frame_difference_top.sv =====
`timescale 1ns / 1ps
// Top level of the Prewitt gradient / frame difference block.
// Depends on pgfd_pkg, pgfd_frame_store, pgfd_window and the assertion header.
`include "prewitt_gradient_and_frame_difference_top_assert.svh"
//
// Usage
//  s_axis: BGR pixels in raster order, blue/green/red in tdata, tuser = 0.
//    tuser = 1 is a drain transfer; after a frame, W+1 drains flush the
//    last W+1 results. Drains at any other time are taken and dropped.
//  m_axis: grad_x, grad_y, temporal_diff in tdata; tlast marks the result
//    of the frame's last pixel.
//  cfg: cfg_index 0 = frame width, 1 = frame height (clamped to 2..MAX).
//    A write restarts the frame; write only while the block is idle.
//  Result order: the result for pixel q belongs to the transfer of pixel
//    q+W+1 (or a drain); it passes stage 1 and stage 2 on its way to
//    the output register.
//  Throughput: one transfer per cycle unless m_axis stalls. Each pixel makes
//    one read and one write-back on the line memory and on the frame memory; a drain only reads the line memory.
//  Reset: the frame memory is zeroed, one entry per cycle, over all
//    2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (65536 by default);
//    s_axis_tready stays low meanwhile, cfg writes are taken.
//  Stall: while m_axis holds a result, items without a result keep
//    flowing; the pipeline stops only when a second result reaches it.
//
module prewitt_gradient_and_frame_difference_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// pixel stream
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [pgfd_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
	input  logic                               s_axis_tuser,  // op
	// result stream
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [pgfd_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // grad_x[10:0], grad_y[21:11],
	                                                          // temporal_diff[30:22], zero[31]
	output logic                               m_axis_tlast,  // frame_end
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pgfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int DW = $clog2(MAX_WIDTH + 2);
	localparam int AW = RW + CW;
	localparam int W_RESET = (160 > MAX_WIDTH) ? MAX_WIDTH : 160;
	localparam int H_RESET = (120 > MAX_HEIGHT) ? MAX_HEIGHT : 120;

	// ---------------- configuration and frame position ----------------
	logic [WW-1:0] w_q, w_clamp;
	logic [HW-1:0] h_q, h_clamp;
	logic [CW-1:0] col_q, pos_col, w_last, dcol, rd_col;
	logic [RW-1:0] row_q, pos_row, h_last;
	logic          done_q;
	logic [DW-1:0] drain_q;
	logic          cfg_acc, acc, op, take_pix, take_drn, drain_ok, drain_last;
	logic          wrap0, lmir0, emit0;
	logic [pgfd_pkg::PIX_W-1:0] in_blue, in_green, in_red;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		if (cfg_data < pgfd_pkg::CFG_DATA_W'(2)) begin
			w_clamp = WW'(2);
		end else if (32'(cfg_data) > MAX_WIDTH) begin
			w_clamp = WW'(MAX_WIDTH);
		end else begin
			w_clamp = WW'(cfg_data);
		end
		if (cfg_data < pgfd_pkg::CFG_DATA_W'(2)) begin
			h_clamp = HW'(2);
		end else if (32'(cfg_data) > MAX_HEIGHT) begin
			h_clamp = HW'(MAX_HEIGHT);
		end else begin
			h_clamp = HW'(cfg_data);
		end
	end

	assign in_blue  = s_axis_tdata[7:0];
	assign in_green = s_axis_tdata[15:8];
	assign in_red   = s_axis_tdata[23:16];
	assign op       = s_axis_tuser;
	assign acc      = s_axis_tvalid && s_axis_tready;

	always_comb begin
		w_last     = CW'(w_q - WW'(1));
		h_last     = RW'(h_q - HW'(1));
		// a pixel after a complete frame starts the next one
		pos_col    = done_q ? '0 : col_q;
		pos_row    = done_q ? '0 : row_q;
		drain_ok   = done_q && (drain_q <= DW'(w_q));
		drain_last = drain_q == DW'(w_q);
		// drains walk a virtual row below the frame; the final one wraps to column 0
		dcol       = drain_last ? '0 : CW'(drain_q);
		take_pix   = acc && !op;
		take_drn   = acc && op && drain_ok;
		rd_col     = op ? dcol : pos_col;
		wrap0      = rd_col == '0;
		lmir0      = rd_col == CW'(1);
		// result lags W+1 items: none for row 0 nor for the first pixel of row 1
		emit0      = op ? 1'b1 : (wrap0 ? (pos_row >= RW'(2)) : (pos_row != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= WW'(W_RESET);
			h_q     <= HW'(H_RESET);
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			drain_q <= '0;
		end else if (cfg_acc) begin
			case (cfg_index)
				pgfd_pkg::REG_FRAME_WIDTH: w_q <= w_clamp;
				pgfd_pkg::REG_FRAME_HEIGHT: h_q <= h_clamp;
				default: ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			drain_q <= '0;
		end else if (take_pix) begin
			if (pos_col == w_last) begin
				col_q <= '0;
				if (pos_row == h_last) begin
					row_q   <= '0;
					done_q  <= 1'b1;
					drain_q <= '0;
				end else begin
					row_q  <= RW'(pos_row + RW'(1));
					done_q <= 1'b0;
				end
			end else begin
				col_q  <= CW'(pos_col + CW'(1));
				row_q  <= pos_row;
				done_q <= 1'b0;
			end
		end else if (take_drn) begin
			drain_q <= DW'(drain_q + DW'(1));
		end
	end

	// ---------------- pipeline flow control ----------------
	logic v_s1, v_s2, out_v_q;
	logic emit_s2;
	logic out_adv, s2_free, s1_free, s1_go, s2_go;
	logic clr_busy;

	assign out_adv       = !out_v_q || m_axis_tready;
	assign s2_free       = !v_s2 || !emit_s2 || out_adv;
	assign s1_free       = !v_s1 || s2_free;
	assign s1_go         = v_s1 && s2_free;
	assign s2_go         = v_s2 && s2_free;
	assign s_axis_tready = s1_free && !clr_busy;

	// ---------------- stage 1: memory read data, gray, column vector ----------------
	logic pix_s1, emit_s1, wrap_s1, lmir_s1, tmir_s1, bmir_s1, fend_s1;
	logic [CW-1:0] col_s1;
	logic [AW-1:0] faddr_s1;
	logic [pgfd_pkg::GRAY_SUM_W-1:0] pb_s1, pg_s1, pr_s1, gsum;
	logic [pgfd_pkg::PIX_W-1:0]      gray, prev_gray;
	logic signed [pgfd_pkg::TD_W-1:0] diff_now, diff_hold_q;
	pgfd_pkg::col_vec_t    vec_now;
	pgfd_pkg::line_entry_t line_mem [MAX_WIDTH];
	pgfd_pkg::line_entry_t line_rd_s1, line_wd;
	logic line_we, line_re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= take_pix || take_drn;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && acc) begin
			pix_s1   <= !op;
			emit_s1  <= emit0;
			wrap_s1  <= wrap0;
			lmir_s1  <= lmir0;
			tmir_s1  <= !op && (pos_row == RW'(1));
			bmir_s1  <= op;
			fend_s1  <= op && drain_last;
			col_s1   <= rd_col;
			faddr_s1 <= {pos_row, pos_col};
			pb_s1    <= pgfd_pkg::GRAY_SUM_W'(in_blue) * pgfd_pkg::COEF_B;
			pg_s1    <= pgfd_pkg::GRAY_SUM_W'(in_green) * pgfd_pkg::COEF_G;
			pr_s1    <= pgfd_pkg::GRAY_SUM_W'(in_red) * pgfd_pkg::COEF_R;
		end
	end

	// line memory: one entry per column, read at accept, written back from stage 1
	assign line_re = take_pix || take_drn;

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[col_s1] <= line_wd;
		end
		if (line_re) begin
			line_rd_s1 <= line_mem[rd_col];
		end
	end

	pgfd_frame_store #(
		.AW(AW)
	) u_frame_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (take_pix),
		.rd_addr({pos_row, pos_col}),
		.rd_data(prev_gray),
		.wr_en  (s1_go && pix_s1),
		.wr_addr(faddr_s1),
		.wr_data(gray),
		.busy   (clr_busy)
	);

	always_comb begin
		gsum     = pb_s1 + pg_s1 + pr_s1 + pgfd_pkg::GRAY_ROUND;
		gray     = gsum[pgfd_pkg::GRAY_SUM_W-1 -: pgfd_pkg::PIX_W];
		diff_now = $signed({1'b0, gray}) - $signed({1'b0, prev_gray});
		// row 0 reads row 1 above it, the virtual drain row reads row H-2 below
		vec_now.top = tmir_s1 ? gray : line_rd_s1.older;
		vec_now.mid = line_rd_s1.newer;
		vec_now.bot = bmir_s1 ? line_rd_s1.older : gray;
		line_wd.older = line_rd_s1.newer;
		line_wd.newer = gray;
		line_wd.diff  = diff_now;
		line_we       = s1_go && pix_s1;
	end

	// ---------------- stage 2: window and gradients ----------------
	logic wrap_s2, lmir_s2, fend_s2;
	pgfd_pkg::col_vec_t vec_s2;
	logic signed [pgfd_pkg::TD_W-1:0]   diff_s2;
	logic signed [pgfd_pkg::GRAD_W-1:0] gx_now, gy_now;
	pgfd_pkg::win_ctl_t win_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	// the emitted difference is the one read by the item before
	always_ff @(posedge clk) begin
		if (s1_go) begin
			emit_s2     <= emit_s1;
			wrap_s2     <= wrap_s1;
			lmir_s2     <= lmir_s1;
			fend_s2     <= fend_s1;
			vec_s2      <= vec_now;
			diff_s2     <= diff_hold_q;
			diff_hold_q <= line_rd_s1.diff;
		end
	end

	assign win_ctl.shift = s2_go;
	assign win_ctl.wrap  = wrap_s2;
	assign win_ctl.lmir  = lmir_s2;

	pgfd_window u_window (
		.clk   (clk),
		.ctl   (win_ctl),
		.vec   (vec_s2),
		.grad_x(gx_now),
		.grad_y(gy_now)
	);

	// ---------------- output register ----------------
	logic signed [pgfd_pkg::GRAD_W-1:0] gx_q, gy_q;
	logic signed [pgfd_pkg::TD_W-1:0]   td_q;
	logic                               fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_go && emit_s2) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go && emit_s2) begin
			gx_q   <= gx_now;
			gy_q   <= gy_now;
			td_q   <= diff_s2;
			fend_q <= fend_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, td_q, gy_q, gx_q};
	assign m_axis_tlast  = fend_q;

	// ---------------- assertions ----------------
	`PGFD_ASSERT_IMPL(a_line_no_overlap, line_we && line_re, col_s1 != rd_col, "line memory read and write-back hit the same column")
	`PGFD_ASSERT(a_col_in_range, 32'(col_q) < 32'(w_q), "column counter reached the frame width")
	`PGFD_ASSERT_IMPL(a_drain_bound, done_q, drain_q <= DW'(DW'(w_q) + DW'(1)), "drain counter ran past W+1")
	`PGFD_ASSERT_IMPL(a_clear_quiet, clr_busy, !v_s1 && !v_s2 && !out_v_q, "pipeline busy during frame memory clear")

endmodule
